// ----- design/dfr_pkg.sv -----
// Shared types and constants for the double remainder unit.
package dfr_pkg;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [63:0] QUIET_NAN    = 64'h7ff8000000000000;

    // Work descriptor passed from the classifier to the remainder engine.
    typedef struct packed {
        logic        done;      // result already known
        logic [63:0] result;    // valid when done
        logic [63:0] sign;      // sign of x in place
        logic [52:0] mx;        // x significand, hidden bit at 52 (may be unnormalized)
        logic [52:0] my;
        logic [12:0] ex;        // signed exponents after unpack
        logic [12:0] ey;
    } dfr_job_t;

endpackage

// ----- design/double_float_remainder.sv -----
// Top level of the double-precision remainder unit.
// Computes the IEEE-754 binary64 fmod of dividend_bits by divisor_bits with
// the sign of the dividend; invalid operands give the quiet NaN
// 0x7FF8000000000000. Special cases skip the engine's loop and go from
// the queue straight to the output; otherwise the result passes through
// subnormal normalization, the exponent-gap loop and renormalization,
// worked through by the single shift-subtract engine that handles one
// exponent step per cycle. The front end keeps accepting into a two-entry
// queue while the engine works, until the queue is full.
module double_float_remainder
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] dividend_bits,
    input  logic [63:0] divisor_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] remainder_bits
);

    dfr_job_t f_job;
    dfr_job_t q_job;
    logic     f_valid;
    logic     f_ready;
    logic     q_valid;
    logic     q_ready;

    dfr_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .dividend_bits, .divisor_bits,
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    dfr_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    dfr_engine u_engine (
        .clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid, .out_ready, .remainder_bits
    );

endmodule

// ----- design/dfr_front.sv -----
// Front part: takes an item, screens the special cases and unpacks operands.
module dfr_front
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] dividend_bits,
    input  logic [63:0] divisor_bits,
    output logic        job_valid,
    input  logic        job_ready,
    output dfr_job_t    job
);

    dfr_job_t    job_reg;
    logic        valid_reg;
    dfr_job_t    job_next;
    logic [10:0] ex;
    logic [10:0] ey;
    logic [63:0] ax;
    logic [63:0] ay;
    logic        y_nan;

    assign ex    = dividend_bits[62:52];
    assign ey    = divisor_bits[62:52];
    assign ax    = {dividend_bits[62:0], 1'b0};
    assign ay    = {divisor_bits[62:0], 1'b0};
    assign y_nan = (ey == EXP_ALL_ONES) && (divisor_bits[51:0] != 52'd0);

    // Subnormals enter with exponent 1 and no hidden bit; the engine
    // normalizes them one bit a cycle.
    always_comb
    begin
        job_next.sign   = {dividend_bits[63], 63'd0};
        job_next.mx     = {(ex != 11'd0), dividend_bits[51:0]};
        job_next.my     = {(ey != 11'd0), divisor_bits[51:0]};
        job_next.ex     = (ex == 11'd0) ? 13'd1 : {2'b00, ex};
        job_next.ey     = (ey == 11'd0) ? 13'd1 : {2'b00, ey};
        job_next.done   = 1'b1;
        job_next.result = dividend_bits;
        if (ay == 64'd0 || y_nan || ex == EXP_ALL_ONES)
        begin
            job_next.result = QUIET_NAN;
        end
        else if (ax == ay)
        begin
            job_next.result = {dividend_bits[63], 63'd0};
        end
        else if (ax < ay)
        begin
            job_next.result = dividend_bits;
        end
        else
        begin
            job_next.done = 1'b0;
        end
    end

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- design/dfr_queue.sv -----
// Two-entry queue that decouples the classifier from the engine.
module dfr_queue
    import dfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  dfr_job_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output dfr_job_t rd_data
);

    dfr_job_t mem_reg [2];
    logic     wptr_reg;
    logic     rptr_reg;
    logic [1:0] count_reg;
    logic     wr_en;
    logic     rd_en;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_en)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/dfr_engine.sv -----
// Back part: normalization, shift-subtract loop, renormalization and packing.
module dfr_engine
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  dfr_job_t    job,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] remainder_bits
);

    typedef enum logic [2:0] {
        S_IDLE, S_NORM_X, S_NORM_Y, S_LOOP, S_RENORM, S_PACK, S_OUT
    } state_t;

    state_t      state_reg;
    logic [53:0] mx_reg;      // one spare bit for the shifted remainder
    logic [52:0] my_reg;
    logic [12:0] ex_reg;
    logic [12:0] ey_reg;
    logic        sign_reg;
    logic [63:0] res_reg;
    logic [54:0] diff;
    logic [12:0] sh;

    assign diff = {1'b0, mx_reg} - {2'b00, my_reg};
    assign sh   = 13'd1 - ex_reg;

    assign job_ready      = (state_reg == S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign remainder_bits = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        mx_reg   <= {1'b0, job.mx};
                        my_reg   <= job.my;
                        ex_reg   <= job.ex;
                        ey_reg   <= job.ey;
                        sign_reg <= job.sign[63];
                        res_reg  <= job.result;
                        state_reg <= job.done ? S_OUT : S_NORM_X;
                    end
                end
                S_NORM_X:
                begin
                    if (mx_reg[52])
                    begin
                        state_reg <= S_NORM_Y;
                    end
                    else
                    begin
                        mx_reg <= {mx_reg[52:0], 1'b0};
                        ex_reg <= ex_reg - 13'd1;
                    end
                end
                S_NORM_Y:
                begin
                    if (my_reg[52])
                    begin
                        state_reg <= S_LOOP;
                    end
                    else
                    begin
                        my_reg <= {my_reg[51:0], 1'b0};
                        ey_reg <= ey_reg - 13'd1;
                    end
                end
                S_LOOP:
                begin
                    // One exponent step per cycle; the final compare uses no shift.
                    if (!diff[54] && diff == 55'd0)
                    begin
                        res_reg   <= {sign_reg, 63'd0};
                        state_reg <= S_OUT;
                    end
                    else if ($signed(ex_reg) > $signed(ey_reg))
                    begin
                        mx_reg <= diff[54] ? {mx_reg[52:0], 1'b0} : {diff[52:0], 1'b0};
                        ex_reg <= ex_reg - 13'd1;
                    end
                    else
                    begin
                        if (!diff[54])
                        begin
                            mx_reg <= diff[53:0];
                        end
                        state_reg <= S_RENORM;
                    end
                end
                S_RENORM:
                begin
                    if (mx_reg[52])
                    begin
                        state_reg <= S_PACK;
                    end
                    else
                    begin
                        mx_reg <= {mx_reg[52:0], 1'b0};
                        ex_reg <= ex_reg - 13'd1;
                    end
                end
                S_PACK:
                begin
                    if (!ex_reg[12] && ex_reg != 13'd0)
                    begin
                        res_reg <= {sign_reg, ex_reg[10:0], mx_reg[51:0]};
                    end
                    else if (sh >= 13'd64)
                    begin
                        res_reg <= {sign_reg, 63'd0};
                    end
                    else
                    begin
                        res_reg <= {sign_reg, 63'd0}
                                 | ({11'd0, mx_reg[52:0]} >> sh[5:0]);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/dfr_checker.sv -----
// Port-level checks for the remainder unit, bound to the top level.
module dfr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] remainder_bits
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(remainder_bits))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid in reset");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(rst_n))
        else $error("result right after reset");

    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && remainder_bits[62:52] == 11'h7ff |-> remainder_bits[62:0] == 63'h7ff8000000000000)
        else $error("non-canonical NaN or infinity out");

endmodule

bind double_float_remainder dfr_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .remainder_bits
);
